// ----- rtl/spm_pkg.sv -----
// Shared types and constants for the sparse polynomial multiplier.
// No dependencies.
package spm_pkg;
  localparam int A_TERMS = 8;
  localparam int B_TERMS = 8;
  localparam int PRODUCT_TERMS = 64;
  localparam int AW = $clog2(A_TERMS);
  localparam int BW = $clog2(B_TERMS);
  localparam int PW = $clog2(PRODUCT_TERMS);

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDOP, ST_MUL, ST_RND, ST_SCAN, ST_ADD, ST_SHDN_RD, ST_SHDN_WR,
    ST_SHUP_RD, ST_SHUP_WR, ST_NEXT, ST_EMIT_RD, ST_EMIT
  } state_t;

  // Round a Q32.32 product to Q16.16, nearest, ties away from zero, saturate.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] m;
    logic [64:0] r;
    neg = p[63];
    m   = neg ? (64'd0 - p) : p;
    m   = (m + 64'd32768) >> 16;
    if (!neg) begin
      r = {1'b0, m};
      qround = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
    end else begin
      r = {1'b0, m};
      qround = (r > 65'h8000_0000) ? 32'sh8000_0000 : 32'(0 - m[31:0]);
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) + 33'(y);
    if (s > 33'sh0_7FFF_FFFF) sat_add = 32'sh7FFF_FFFF;
    else if (s < -33'sh0_8000_0000) sat_add = 32'sh8000_0000;
    else sat_add = s[31:0];
  endfunction
endpackage

// ----- rtl/spm_acc_ram.sv -----
// Accumulator store: one write port, one registered read port.
// Depends on spm_pkg.
module spm_acc_ram import spm_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [PW-1:0]      waddr,
  input  logic [47:0]        wdata,
  input  logic [PW-1:0]      raddr,
  output logic [47:0]        rdata
);
  logic [47:0] mem [PRODUCT_TERMS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/sparse_polynomial_multiply_core.sv -----
// Sparse polynomial multiplier, top level: term stores, sequencer, output register.
// Depends on spm_pkg and spm_acc_ram.
//
// Usage: input words on in_* carry a command in in_tuser (load A term, load B
// term, compute, clear) and a term in in_tdata. Loads and clears give no
// output. A compute walks every A/B term pair with one shared 32x32
// multiplier and merges each product into a descending accumulator held in a
// single-port-write RAM; inserts and deletes shift the entries one at a time,
// each by a read and then a write. Per pair: operand read, multiply, round,
// then a scan of the entries (read, compare) and any add or shift; the
// accumulator holds up to 64 entries. Results then stream one word at a time,
// each read from the RAM before it is sent; the last word has out_tlast. An
// empty product gives one word with the empty flag set.
// in_tready is low for the whole compute and emission. When the receiver
// stalls, the output register holds its word and the sequencer waits.
// Reset (rst_n low, synchronous) clears term counts, accumulator count, the
// sticky overflow flag and the sequencer; stores need no reset.
module sparse_polynomial_multiply_core import spm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coef_in[31:0], exponent_in[46:32], pad
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // coef_out[31:0], exponent_out[47:32]
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // empty_res, overflow
);
  logic [31:0] a_coef [A_TERMS];
  logic [14:0] a_exp  [A_TERMS];
  logic [31:0] b_coef [B_TERMS];
  logic [14:0] b_exp  [B_TERMS];
  logic [AW:0] a_cnt_r;
  logic [BW:0] b_cnt_r;
  logic [PW:0] acc_cnt_r, acc_cnt_nxt;
  logic        ovf_r, ovf_nxt;
  state_t      st_r, st_nxt;
  logic [AW:0] i_r, i_nxt;
  logic [BW:0] j_r, j_nxt;
  logic [PW:0] k_r, k_nxt;
  logic signed [31:0] opa_r, opa_nxt, opb_r, opb_nxt, c_r, c_nxt;
  logic [15:0] e_r, e_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic        ram_we;
  logic [PW-1:0] ram_wa, ram_ra;
  logic [47:0] ram_wd, ram_rd;
  logic        ov_r, ov_nxt;
  logic [47:0] od_r, od_nxt;
  logic        ol_r, ol_nxt, oe_r, oe_nxt, oo_r, oo_nxt;
  logic        in_acc;
  logic signed [31:0] sum;

  spm_acc_ram u_ram (.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
                     .raddr(ram_ra), .rdata(ram_rd));

  assign in_tready = (st_r == ST_IDLE) && !ov_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = {oo_r, oe_r};
  assign sum = sat_add($signed(ram_rd[31:0]), c_r);

  // term stores
  always_ff @(posedge clk) begin
    if (in_acc && cmd_t'(in_tuser) == CMD_LOAD_A && a_cnt_r < (AW+1)'(A_TERMS)) begin
      a_coef[a_cnt_r[AW-1:0]] <= in_tdata[31:0];
      a_exp[a_cnt_r[AW-1:0]]  <= in_tdata[46:32];
    end
    if (in_acc && cmd_t'(in_tuser) == CMD_LOAD_B && b_cnt_r < (BW+1)'(B_TERMS)) begin
      b_coef[b_cnt_r[BW-1:0]] <= in_tdata[31:0];
      b_exp[b_cnt_r[BW-1:0]]  <= in_tdata[46:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; a_cnt_r <= '0; b_cnt_r <= '0; acc_cnt_r <= '0;
      ovf_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; acc_cnt_r <= acc_cnt_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
      if (in_acc) begin
        case (cmd_t'(in_tuser))
          CMD_LOAD_A: if (a_cnt_r < (AW+1)'(A_TERMS)) a_cnt_r <= a_cnt_r + 1'b1;
          CMD_LOAD_B: if (b_cnt_r < (BW+1)'(B_TERMS)) b_cnt_r <= b_cnt_r + 1'b1;
          CMD_CLEAR: begin
            a_cnt_r <= '0; b_cnt_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; opa_r <= opa_nxt; opb_r <= opb_nxt;
    c_r <= c_nxt; e_r <= e_nxt; prod_r <= prod_nxt; od_r <= od_nxt;
    ol_r <= ol_nxt; oe_r <= oe_nxt; oo_r <= oo_nxt;
  end

  always_comb begin
    st_nxt = st_r; acc_cnt_nxt = acc_cnt_r; ovf_nxt = ovf_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; opa_nxt = opa_r; opb_nxt = opb_r;
    c_nxt = c_r; e_nxt = e_r; prod_nxt = prod_r;
    ov_nxt = ov_r; od_nxt = od_r; ol_nxt = ol_r; oe_nxt = oe_r; oo_nxt = oo_r;
    ram_we = 1'b0; ram_wa = k_r[PW-1:0]; ram_wd = {e_r, c_r}; ram_ra = k_r[PW-1:0];
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_tuser))
            CMD_LOAD_A: if (a_cnt_r == (AW+1)'(A_TERMS)) ovf_nxt = 1'b1;
            CMD_LOAD_B: if (b_cnt_r == (BW+1)'(B_TERMS)) ovf_nxt = 1'b1;
            CMD_CLEAR: begin
              acc_cnt_nxt = '0; ovf_nxt = 1'b0;
            end
            default: begin
              acc_cnt_nxt = '0; i_nxt = '0; j_nxt = '0;
              if (a_cnt_r != '0 && b_cnt_r != '0) st_nxt = ST_RDOP;
              else begin
                k_nxt = '0; st_nxt = ST_EMIT_RD;
              end
            end
          endcase
        end
      end
      ST_RDOP: begin
        opa_nxt = a_coef[i_r[AW-1:0]]; opb_nxt = b_coef[j_r[BW-1:0]];
        e_nxt = 16'(a_exp[i_r[AW-1:0]]) + 16'(b_exp[j_r[BW-1:0]]);
        st_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt = opa_r * opb_r; st_nxt = ST_RND;
      end
      ST_RND: begin
        c_nxt = qround(prod_r); k_nxt = '0; st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // issue read of entry k
        if (k_r == acc_cnt_r) begin
          if (acc_cnt_r == (PW+1)'(PRODUCT_TERMS)) begin
            ovf_nxt = 1'b1; st_nxt = ST_NEXT;
          end else begin
            ram_we = 1'b1; acc_cnt_nxt = acc_cnt_r + 1'b1; st_nxt = ST_NEXT;
          end
        end else st_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (ram_rd[47:32] > e_r) begin
          k_nxt = k_r + 1'b1; st_nxt = ST_SCAN;
        end else if (ram_rd[47:32] == e_r) begin
          if (sum != 32'sd0) begin
            ram_we = 1'b1; ram_wd = {e_r, sum}; st_nxt = ST_NEXT;
          end else begin
            acc_cnt_nxt = acc_cnt_r - 1'b1; st_nxt = ST_SHDN_RD;
          end
        end else if (acc_cnt_r == (PW+1)'(PRODUCT_TERMS)) begin
          ovf_nxt = 1'b1; st_nxt = ST_NEXT;
        end else begin
          // insert at k: shift [k, cnt) up, walking from the top
          ram_ra = PW'(acc_cnt_r - 1'b1); k_nxt = acc_cnt_r;
          acc_cnt_nxt = acc_cnt_r + 1'b1; st_nxt = ST_SHUP_WR;
          opa_nxt = 32'(k_r);
        end
      end
      ST_SHDN_RD: begin
        // move entry k+1 to k until count reached
        if (k_r == acc_cnt_r) st_nxt = ST_NEXT;
        else begin
          ram_ra = PW'(k_r + 1'b1); st_nxt = ST_SHDN_WR;
        end
      end
      ST_SHDN_WR: begin
        ram_we = 1'b1; ram_wd = ram_rd; k_nxt = k_r + 1'b1; st_nxt = ST_SHDN_RD;
      end
      ST_SHUP_WR: begin
        // ram_rd holds entry k-1; write it to k
        ram_we = 1'b1; ram_wd = ram_rd;
        k_nxt = k_r - 1'b1; st_nxt = ST_SHUP_RD;
      end
      ST_SHUP_RD: begin
        if (k_r == opa_r[PW:0]) begin
          ram_we = 1'b1; st_nxt = ST_NEXT;
        end else begin
          ram_ra = PW'(k_r - 1'b1); st_nxt = ST_SHUP_WR;
        end
      end
      ST_NEXT: begin
        if (j_r + 1'b1 < b_cnt_r) begin
          j_nxt = j_r + 1'b1; st_nxt = ST_RDOP;
        end else if (i_r + 1'b1 < (AW+1)'(a_cnt_r)) begin
          j_nxt = '0; i_nxt = i_r + 1'b1; st_nxt = ST_RDOP;
        end else begin
          k_nxt = '0; st_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; oo_nxt = ovf_r;
          if (acc_cnt_r == '0) begin
            od_nxt = '0; ol_nxt = 1'b1; oe_nxt = 1'b1; st_nxt = ST_IDLE;
          end else begin
            od_nxt = ram_rd; oe_nxt = 1'b0;
            ol_nxt = (k_r + 1'b1 == acc_cnt_r);
            k_nxt = k_r + 1'b1;
            st_nxt = (k_r + 1'b1 == acc_cnt_r) ? ST_IDLE : ST_EMIT_RD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/spm_checker.sv -----
// Port-level checks for the sparse polynomial multiplier, bound to the top.
// Depends on sparse_polynomial_multiply_core ports only.
module spm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == 48'd0)
    else $error("empty word not last or not zero");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while output pending");
endmodule

bind sparse_polynomial_multiply_core spm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast),
  .out_tuser(out_tuser));

// ----- bench/spm_checker.sv -----
// Checker for the sparse polynomial multiplier: watches both streams, predicts
// product terms from accepted input words and compares them with output words.
// Depends on spm_pkg.
module spm_scoreboard import spm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          terms_pending
);
  typedef struct packed {
    logic signed [31:0] coef;
    logic [15:0]        expo;
    logic               last;
    logic               empty;
    logic               ovf;
  } term_word_t;

  term_word_t product_q[$];

  logic signed [31:0] ta_coef [A_TERMS];
  logic [14:0]        ta_exp  [A_TERMS];
  logic signed [31:0] tb_coef [B_TERMS];
  logic [14:0]        tb_exp  [B_TERMS];
  int                 na = 0, nb = 0, nacc = 0;
  logic signed [31:0] sum_coef [PRODUCT_TERMS];
  logic [15:0]        sum_exp  [PRODUCT_TERMS];
  logic               ovf_flag = 1'b0;
  int                 fails = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q16.16 multiply, round to nearest with ties away from zero
  function automatic logic signed [31:0] fix_mul(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    longint p, r;
    logic [63:0] m;
    p = longint'(x) * longint'(y);
    m = (p < 0) ? 64'(-p) : 64'(p);
    m = (m + 64'd32768) >> 16;
    r = (p < 0) ? -longint'(m) : longint'(m);
    return clamp32(r);
  endfunction

  // merge one partial product into the descending accumulator
  task automatic merge_term(input logic signed [31:0] c, input logic [15:0] e);
    int i;
    logic signed [31:0] s;
    i = 0;
    while (i < nacc && sum_exp[i] > e) i++;
    if (i < nacc && sum_exp[i] == e) begin
      s = clamp32(longint'(sum_coef[i]) + longint'(c));
      if (s == 0) begin
        for (int k = i; k < nacc - 1; k++) begin
          sum_coef[k] = sum_coef[k+1];
          sum_exp[k]  = sum_exp[k+1];
        end
        nacc--;
      end else begin
        sum_coef[i] = s;
      end
      return;
    end
    if (nacc >= PRODUCT_TERMS) begin
      ovf_flag = 1'b1;
      return;
    end
    for (int k = nacc; k > i; k--) begin
      sum_coef[k] = sum_coef[k-1];
      sum_exp[k]  = sum_exp[k-1];
    end
    sum_coef[i] = c;
    sum_exp[i]  = e;
    nacc++;
  endtask

  task automatic predict_word(input cmd_t cmd, input logic signed [31:0] c,
                              input logic [14:0] e);
    term_word_t w;
    case (cmd)
      CMD_LOAD_A: begin
        if (na < A_TERMS) begin
          ta_coef[na] = c; ta_exp[na] = e; na++;
        end else ovf_flag = 1'b1;
      end
      CMD_LOAD_B: begin
        if (nb < B_TERMS) begin
          tb_coef[nb] = c; tb_exp[nb] = e; nb++;
        end else ovf_flag = 1'b1;
      end
      CMD_CLEAR: begin
        na = 0; nb = 0; nacc = 0; ovf_flag = 1'b0;
      end
      default: begin
        nacc = 0;
        for (int i = 0; i < na; i++)
          for (int j = 0; j < nb; j++)
            merge_term(fix_mul(ta_coef[i], tb_coef[j]),
                       16'(ta_exp[i]) + 16'(tb_exp[j]));
        if (nacc == 0) begin
          w = '{coef: 0, expo: 0, last: 1'b1, empty: 1'b1, ovf: ovf_flag};
          product_q.push_back(w);
        end else begin
          for (int k = 0; k < nacc; k++) begin
            w = '{coef: sum_coef[k], expo: sum_exp[k], last: (k == nacc - 1),
                  empty: 1'b0, ovf: ovf_flag};
            product_q.push_back(w);
          end
        end
      end
    endcase
  endtask

  assign fail_count    = fails;
  assign terms_pending = product_q.size();

  always @(posedge clk) begin
    term_word_t got, exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{coef: out_tdata[31:0], expo: out_tdata[47:32], last: out_tlast,
              empty: out_tuser[0], ovf: out_tuser[1]};
      if (product_q.size() == 0) begin
        $display("%0t: unexpected word coef=%h exp=%0d last=%b empty=%b ovf=%b",
                 $time, got.coef, got.expo, got.last, got.empty, got.ovf);
        fails++;
      end else begin
        exp_w = product_q.pop_front();
        if (got.last !== exp_w.last || got.empty !== exp_w.empty ||
            got.ovf !== exp_w.ovf ||
            got.coef !== exp_w.coef || got.expo !== exp_w.expo) begin
          $display("%0t: mismatch expected coef=%h exp=%0d last=%b empty=%b ovf=%b",
                   $time, exp_w.coef, exp_w.expo, exp_w.last, exp_w.empty, exp_w.ovf);
          $display("%0t:          actual   coef=%h exp=%0d last=%b empty=%b ovf=%b",
                   $time, got.coef, got.expo, got.last, got.empty, got.ovf);
          fails++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      predict_word(cmd_t'(in_tuser), in_tdata[31:0], in_tdata[46:32]);
  end
endmodule

// ----- bench/tb_sparse_polynomial_multiply_core.sv -----
// Testbench top for the sparse polynomial multiplier: clock, reset, term and
// command stimulus, receiver back-pressure and the verdict.
// Depends on spm_pkg, sparse_polynomial_multiply_core and spm_scoreboard.
module tb_sparse_polynomial_multiply_core;
  import spm_pkg::*;

  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int     RANDOM_WORDS = 440;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // coef_in[31:0], exponent_in[46:32], pad
  logic [1:0]  in_tuser = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // coef_out[31:0], exponent_out[47:32]
  logic        out_tlast;
  logic [1:0]  out_tuser;       // empty_res, overflow

  int     fail_count, terms_pending;
  int     tx_idle_pct = 26;     // sender idle chance per word, percent
  int     rx_idle_pct = 58;     // receiver idle chance per cycle, percent
  logic   hold_req = 1'b0;      // ask the receiver for one long hold-off
  longint cycles = 0;
  int     words_sent = 0;

  sparse_polynomial_multiply_core dut (.*);

  spm_scoreboard chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: counts cycles, ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Drive one word and wait for it to be taken. Leaves in_tvalid high so
  // back-to-back words need no gap.
  task automatic send_word(input cmd_t cmd, input logic [31:0] coef,
                           input logic [14:0] expo);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, expo, coef};
    taken = 1'b0;
    while (!taken) begin
      #1 taken = in_tready;     // ready is settled well before the next edge
      @(negedge clk);
    end
    words_sent++;
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return ($urandom_range(1)) ? 32'h0001_0000 : 32'hFFFF_0000;  // +-1.0
      3: return 32'h0;
      4, 5: return $urandom;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [14:0] pick_exp();
    // narrow range makes exponent collisions and cancellations common
    if ($urandom_range(4) == 0) return 15'($urandom);
    return 15'($urandom_range(6));
  endfunction

  // Job: optional clear, some A and B terms, an occasional random noise word, compute.
  task automatic random_job();
    int na_job, nb_job;
    logic [14:0] e;
    if ($urandom_range(3) == 0)
      send_word(CMD_CLEAR, $urandom, 15'($urandom));
    na_job = ($urandom_range(9) == 0) ? $urandom_range(9) : $urandom_range(3);
    nb_job = ($urandom_range(9) == 0) ? $urandom_range(9) : $urandom_range(3);
    e = 15'($urandom_range(8) + 8);
    for (int i = 0; i < na_job; i++) begin
      // mostly descending exponents, sometimes arbitrary
      e = ($urandom_range(3) == 0) ? pick_exp() : ((e > 15'd0) ? e - 15'd1 : 15'd0);
      send_word(CMD_LOAD_A, pick_coef(), e);
    end
    e = 15'($urandom_range(8) + 8);
    for (int i = 0; i < nb_job; i++) begin
      e = ($urandom_range(3) == 0) ? pick_exp() : ((e > 15'd0) ? e - 15'd1 : 15'd0);
      send_word(CMD_LOAD_B, pick_coef(), e);
    end
    if ($urandom_range(7) == 0)
      send_word(cmd_t'($urandom_range(3)), $urandom, 15'($urandom));  // noise
    send_word(CMD_COMPUTE, $urandom, 15'($urandom));
  endtask

  initial begin
    int start;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty product first
    send_word(CMD_COMPUTE, 32'h0, 15'h0);
    // field extremes, saturation both ways
    send_word(CMD_LOAD_A, 32'h8000_0000, 15'h7FFF);
    send_word(CMD_LOAD_A, 32'h7FFF_FFFF, 15'h0);
    send_word(CMD_LOAD_B, 32'h8000_0000, 15'h7FFF);
    send_word(CMD_LOAD_B, 32'h7FFF_FFFF, 15'h0);
    send_word(CMD_COMPUTE, 32'hFFFF_FFFF, 15'h7FFF);
    // (x+1)(x-1): middle terms cancel to zero and drop out
    send_word(CMD_CLEAR, 32'hFFFF_FFFF, 15'h7FFF);
    send_word(CMD_LOAD_A, 32'h0001_0000, 15'd1);
    send_word(CMD_LOAD_A, 32'h0001_0000, 15'd0);
    send_word(CMD_LOAD_B, 32'h0001_0000, 15'd1);
    send_word(CMD_LOAD_B, 32'hFFFF_0000, 15'd0);
    send_word(CMD_COMPUTE, 32'h0, 15'h0);
    // zero coefficient with a new exponent stays as a term
    send_word(CMD_CLEAR, 32'h0, 15'h0);
    send_word(CMD_LOAD_A, 32'h0, 15'd3);
    send_word(CMD_LOAD_B, 32'h0002_8000, 15'd2);
    send_word(CMD_COMPUTE, 32'h0, 15'h0);
    // loads past capacity set the sticky flag
    for (int i = 0; i < 9; i++)
      send_word(CMD_LOAD_B, 32'h0000_8000, 15'(9 - i));
    send_word(CMD_COMPUTE, 32'h0, 15'h0);

    // Random jobs in three idling phases; long hold-off in the last one
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      if (words_sent - start >= RANDOM_WORDS / 3 && tx_idle_pct == 26) begin
        tx_idle_pct = 58; rx_idle_pct = 26;
      end else if (words_sent - start >= 2 * RANDOM_WORDS / 3 && tx_idle_pct != 0) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      random_job();
    end
    in_tvalid <= 1'b0;

    while (terms_pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
